// ----- hdl/spmv_pkg.sv -----
// ----------------------------------------------------------------------------
// spmv_pkg
// shared types and constants of the sparse matrix vector multiply block
// ----------------------------------------------------------------------------
package spmv_pkg;

  // field widths
  localparam int CMD_W   = 2;
  localparam int COL_W   = 10;
  localparam int VAL_W   = 16;
  localparam int ROW_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 40;

  // dense vector
  localparam int VECTOR_LENGTH = 1024;
  localparam int STORE_DEPTH   = 1 << COL_W;
  localparam int RANGE_W       = COL_W + 7;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NONZERO   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMPTY_ROW = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESTART   = 2'd3;

  // saturation bounds of the row sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] operand_value;
    logic                    last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;
  } out_item_t;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_MAC,
    OP_MAC_LAST,
    OP_EMPTY,
    OP_RESTART
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] elem;
  } op_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } queue_status_t;

endpackage

// ----- hdl/spmv_front.sv -----
// ----------------------------------------------------------------------------
// spmv_front
// accepts transactions, keeps the vector store and classifies operations
// ----------------------------------------------------------------------------
module spmv_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  spmv_pkg::in_item_t      in_data,
  input  spmv_pkg::queue_status_t q_status,
  output logic                    push,
  output spmv_pkg::op_t           push_op
);

  logic [spmv_pkg::VAL_W-1:0] mem [spmv_pkg::STORE_DEPTH];

  logic                        accept;
  logic                        in_range;
  spmv_pkg::op_kind_t          kind_nxt;
  logic [spmv_pkg::QCNT_W:0]   credit_used;

  logic                        stg_valid_r;
  logic                        stg_push_r;
  spmv_pkg::op_kind_t          stg_kind_r;
  logic signed [spmv_pkg::VAL_W-1:0] stg_value_r;
  logic                        stg_in_range_r;
  logic [spmv_pkg::VAL_W-1:0]  rd_data_r;

  // queue entries plus the one in the read stage
  assign credit_used = {1'b0, q_status.count} + (spmv_pkg::QCNT_W + 1)'(stg_valid_r);
  assign in_stall    = credit_used >= (spmv_pkg::QCNT_W + 1)'(spmv_pkg::QUEUE_DEPTH);
  assign accept      = in_valid && !in_stall;
  assign in_range    = spmv_pkg::RANGE_W'(in_data.column)
                       < spmv_pkg::RANGE_W'(spmv_pkg::VECTOR_LENGTH);

  always_comb begin
    case (in_data.command)
      spmv_pkg::CMD_NONZERO: begin
        kind_nxt = in_data.last_in_row ? spmv_pkg::OP_MAC_LAST : spmv_pkg::OP_MAC;
      end
      spmv_pkg::CMD_EMPTY_ROW: begin
        kind_nxt = spmv_pkg::OP_EMPTY;
      end
      default: begin
        kind_nxt = spmv_pkg::OP_RESTART;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      stg_push_r  <= 1'b0;
    end else begin
      stg_valid_r <= accept;
      stg_push_r  <= accept && (in_data.command != spmv_pkg::CMD_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_kind_r     <= kind_nxt;
      stg_value_r    <= in_data.operand_value;
      stg_in_range_r <= in_range;
    end
  end

  // vector store: write on load, registered read for every transaction
  always_ff @(posedge clk) begin
    if (accept && in_data.command == spmv_pkg::CMD_LOAD && in_range) begin
      mem[in_data.column] <= in_data.operand_value;
    end
    if (accept) begin
      rd_data_r <= mem[in_data.column];
    end
  end

  assign push          = stg_push_r;
  assign push_op.kind  = stg_kind_r;
  assign push_op.value = stg_value_r;
  assign push_op.elem  = stg_in_range_r ? $signed(rd_data_r) : '0;

endmodule

// ----- hdl/spmv_queue.sv -----
// ----------------------------------------------------------------------------
// spmv_queue
// short fifo of operations between front and back
// ----------------------------------------------------------------------------
module spmv_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  spmv_pkg::op_t           push_op,
  input  logic                    pop,
  output spmv_pkg::op_t           head_op,
  output spmv_pkg::queue_status_t status
);

  spmv_pkg::op_t               entries [spmv_pkg::QUEUE_DEPTH];
  logic [spmv_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [spmv_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [spmv_pkg::QCNT_W-1:0] count_r;
  logic [spmv_pkg::QCNT_W-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + spmv_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - spmv_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + spmv_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + spmv_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_op;
    end
  end

  assign head_op      = entries[rd_ptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r < spmv_pkg::QCNT_W'(spmv_pkg::QUEUE_DEPTH))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spmv_pkg::QCNT_W'(spmv_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ----- hdl/spmv_back.sv -----
// ----------------------------------------------------------------------------
// spmv_back
// multiply, saturating row accumulation and result register
// ----------------------------------------------------------------------------
module spmv_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  spmv_pkg::queue_status_t q_status,
  input  spmv_pkg::op_t           head_op,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output spmv_pkg::out_item_t     out_data
);

  logic                                advance;
  logic                                emit;

  logic                                mul_valid_r;
  spmv_pkg::op_kind_t                  mul_kind_r;
  logic signed [spmv_pkg::PROD_W-1:0]  prod_r;

  logic signed [spmv_pkg::SUM_W-1:0]   acc_r;
  logic                                clip_r;
  logic [spmv_pkg::ROW_W-1:0]          row_r;

  logic signed [spmv_pkg::SUM_W:0]     sum_wide;
  logic signed [spmv_pkg::SUM_W-1:0]   sum_sat;
  logic                                clip_now;

  logic                                out_valid_r;
  spmv_pkg::out_item_t                 out_item_r;

  // whole back pipeline moves when the result register can take a value
  assign advance = !out_valid_r || !out_stall;
  assign pop     = advance && !q_status.empty;
  assign emit    = advance && mul_valid_r
                   && (mul_kind_r == spmv_pkg::OP_MAC_LAST || mul_kind_r == spmv_pkg::OP_EMPTY);

  // exact add, then clamp to 40 bits
  always_comb begin
    sum_wide = $signed({acc_r[spmv_pkg::SUM_W-1], acc_r})
               + (spmv_pkg::SUM_W + 1)'(prod_r);
    clip_now = 1'b0;
    sum_sat  = sum_wide[spmv_pkg::SUM_W-1:0];
    if (!sum_wide[spmv_pkg::SUM_W] && sum_wide[spmv_pkg::SUM_W-1]) begin
      sum_sat  = spmv_pkg::SUM_MAX;
      clip_now = 1'b1;
    end else if (sum_wide[spmv_pkg::SUM_W] && !sum_wide[spmv_pkg::SUM_W-1]) begin
      sum_sat  = spmv_pkg::SUM_MIN;
      clip_now = 1'b1;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (advance) begin
      mul_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mul_kind_r <= head_op.kind;
      prod_r     <= head_op.value * head_op.elem;
    end
  end

  // accumulate stage and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      clip_r      <= 1'b0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance && mul_valid_r) begin
        case (mul_kind_r)
          spmv_pkg::OP_MAC: begin
            acc_r  <= sum_sat;
            clip_r <= clip_r || clip_now;
          end
          spmv_pkg::OP_MAC_LAST, spmv_pkg::OP_EMPTY: begin
            acc_r  <= '0;
            clip_r <= 1'b0;
            row_r  <= row_r + spmv_pkg::ROW_W'(1);
          end
          spmv_pkg::OP_RESTART: begin
            acc_r  <= '0;
            clip_r <= 1'b0;
            row_r  <= '0;
          end
          default: begin
            acc_r <= acc_r;
          end
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.row_index <= row_r;
      if (mul_kind_r == spmv_pkg::OP_MAC_LAST) begin
        out_item_r.row_sum   <= sum_sat;
        out_item_r.saturated <= clip_r || clip_now;
      end else begin
        out_item_r.row_sum   <= '0;
        out_item_r.saturated <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTHESIS
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> acc_r == '0 && !clip_r)
    else $error("row state not cleared after result");

  a_restart_row: assert property (@(posedge clk) disable iff (!rst_n)
    advance && mul_valid_r && mul_kind_r == spmv_pkg::OP_RESTART |=> row_r == '0)
    else $error("row counter not cleared on restart");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(acc_r) && $stable(row_r) && !$past(pop))
    else $error("back pipeline moved while result stalled");
`endif

endmodule

// ----- hdl/sparse_matrix_vector_multiply.sv -----
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// y = A*x for a matrix streamed in compressed row order
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_stall is low: a load writes a Q8.8
// vector element into a 1024-entry store, a nonzero multiplies its Q8.8 value
// by the stored element at its column and adds the exact product into a
// 40-bit Q24.16 saturating row accumulator, and a nonzero with last_in_row
// set (or an empty-row command) produces one result with the row index, the
// row sum and a sticky saturation flag. A restart command sets the row index
// back to zero and keeps the vector. While neither channel stalls, the rate is
// one transaction per cycle, set by the one vector store access per
// transaction in the front and the one multiply-accumulate per cycle in the
// back, which out_stall can hold. The store is read at the edge that takes a
// transaction; the result then passes the queue write, the multiply and the
// accumulate into the result register. A four-entry queue sits between front
// and back; in_stall rises once that queue and the read stage together hold
// four operations, which happens only after out_stall has held the back. A
// nonzero may follow the load of its element in the very next cycle. Elements
// that were never loaded read as whatever the store holds.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply (
  input  logic                clk,
  input  logic                rst_n,
  // input transactions
  input  logic                in_valid,
  output logic                in_stall,
  input  spmv_pkg::in_item_t  in_data,
  // result transactions
  output logic                out_valid,
  input  logic                out_stall,
  output spmv_pkg::out_item_t out_data
);

  // front to queue
  logic                    push;
  spmv_pkg::op_t           push_op;

  // queue to back
  logic                    pop;
  spmv_pkg::op_t           head_op;
  spmv_pkg::queue_status_t q_status;

  // front: vector store and command decode
  spmv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_op  (push_op)
  );

  // decoupling queue
  spmv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  // back: multiply, accumulate, result register
  spmv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb_sparse_matrix_vector_multiply.sv -----
// ----------------------------------------------------------------------------
// tb_sparse_matrix_vector_multiply
// self-checking bench for the streamed sparse matrix vector multiply
// ----------------------------------------------------------------------------
// A sequencer fills a queue with matrix stream transactions: a directed
// opening, then random rows, mostly well-formed, under four pacing schemes. A clocked
// driver offers the queued transactions. Each accepted transaction goes
// through a bit-exact row predictor, and every row it finishes is queued as
// the expected result. A clocked monitor stalls the result channel at random,
// or for one long hold, and compares each accepted result field by field with
// the oldest expected row.
// ----------------------------------------------------------------------------
module tb_sparse_matrix_vector_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  import spmv_pkg::*;

  // pacing of the two channels
  typedef enum int {
    PACE_FULL,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_t;

  localparam int RX_HOLD_CYCLES  = 80;    // long receiver hold, fills the block
  localparam int QUIET_LIMIT     = 2000;  // cycles with no transaction at all
  localparam int SETTLE_CYCLES   = 20;    // settling time before the final verdict
  localparam int RANDOM_PER_PACE = 138;   // about 550 random transactions in total

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sparse_matrix_vector_multiply dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // stimulus and expectations
  in_item_t  matrix_stream[$];   // transactions waiting for the driver
  out_item_t expected_rows[$];   // finished rows not yet seen at the output
  int        queued_count = 0;
  int        mismatches   = 0;
  pace_t     pace         = PACE_FULL;
  int        hold_requests = 0;  // bumped by the sequencer, served by the monitor
  int        holds_served  = 0;
  int        hold_left     = 0;
  int        quiet_cycles  = 0;

  // columns that already hold a vector element, so no nonzero reads junk
  bit        column_loaded[STORE_DEPTH];
  int        loaded_columns[$];

  // own copy of the block state
  logic signed [VAL_W-1:0] element_copy[STORE_DEPTH];
  logic signed [SUM_W-1:0] row_total;
  logic [ROW_W-1:0]        row_number;
  logic                    row_clipped;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // bit-exact row arithmetic: exact Q16.16 product, clamp to the 40-bit range
  task automatic compute_row_result(input in_item_t t);
    longint    factor;
    longint    total;
    out_item_t row;
    case (t.command)
      CMD_LOAD: begin
        if (t.column < VECTOR_LENGTH) element_copy[t.column] = t.operand_value;
      end
      CMD_NONZERO: begin
        factor = 0;
        if (t.column < VECTOR_LENGTH) factor = longint'(element_copy[t.column]);
        total = longint'(row_total) + longint'(t.operand_value) * factor;
        if (total > longint'(SUM_MAX)) begin
          total = longint'(SUM_MAX);
          row_clipped = 1'b1;
        end else if (total < longint'(SUM_MIN)) begin
          total = longint'(SUM_MIN);
          row_clipped = 1'b1;
        end
        row_total = total[SUM_W-1:0];
        if (t.last_in_row) begin
          row.row_index = row_number;
          row.row_sum   = row_total;
          row.saturated = row_clipped;
          expected_rows.push_back(row);
          row_number++;
          row_total   = '0;
          row_clipped = 1'b0;
        end
      end
      CMD_EMPTY_ROW: begin
        // any partial sum of the row is dropped
        row.row_index = row_number;
        row.row_sum   = '0;
        row.saturated = 1'b0;
        expected_rows.push_back(row);
        row_number++;
        row_total   = '0;
        row_clipped = 1'b0;
      end
      default: begin
        // restart keeps the vector
        row_number  = '0;
        row_total   = '0;
        row_clipped = 1'b0;
      end
    endcase
  endtask

  function automatic int sender_idle_pct(input pace_t p);
    case (p)
      PACE_SENDER_GAPS: return 63;
      PACE_BOTH:        return 31;
      default:          return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input pace_t p);
    case (p)
      PACE_RECEIVER_STALLS: return 63;
      PACE_BOTH:            return 31;
      default:              return 0;
    endcase
  endfunction

  // driver: a new transaction goes out only once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) compute_row_result(in_data);
      if (!in_valid || !in_stall) begin
        if (matrix_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct(pace)) begin
          in_data  <= matrix_stream.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result, then picks the next stall value
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("result row %0d sum %0d with nothing expected",
                                    out_data.row_index, out_data.row_sum));
        end else begin
          want = expected_rows.pop_front();
          if (out_data.row_index !== want.row_index)
            report_mismatch($sformatf("row_index got %0d want %0d",
                                      out_data.row_index, want.row_index));
          if (out_data.row_sum !== want.row_sum)
            report_mismatch($sformatf("row %0d row_sum got %0d want %0d",
                                      want.row_index, out_data.row_sum, want.row_sum));
          if (out_data.saturated !== want.saturated)
            report_mismatch($sformatf("row %0d saturated got %0b want %0b",
                                      want.row_index, out_data.saturated,
                                      want.saturated));
        end
      end
      // a long hold, counted here, lets the block fill and stall its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_requests != holds_served) begin
        holds_served <= hold_requests;
        hold_left    <= RX_HOLD_CYCLES - 1;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct(pace));
      end
    end
  end

  // watchdog: too long without a transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input int col,
                            input logic [VAL_W-1:0] val, input bit last);
    in_item_t t;
    t.command       = cmd;
    t.column        = col[COL_W-1:0];
    t.operand_value = val;
    t.last_in_row   = last;
    matrix_stream.push_back(t);
    queued_count++;
    if (cmd == CMD_LOAD && !column_loaded[col]) begin
      column_loaded[col] = 1'b1;
      loaded_columns.push_back(col);
    end
  endtask

  // mostly random, with the extremes of Q8.8 often enough
  function automatic logic [VAL_W-1:0] random_operand();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  function automatic int pick_loaded();
    return loaded_columns[$urandom_range(loaded_columns.size() - 1)];
  endfunction

  // well-formed rows with random content, plus some loads and broken rows
  task automatic stream_random(input int count);
    int stop;
    int kind;
    int len;
    stop = queued_count + count;
    while (queued_count < stop) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        len = $urandom_range(1, 3);
        repeat (len) queue_item(CMD_LOAD, $urandom_range(STORE_DEPTH - 1),
                                random_operand(), 1'($urandom_range(1)));
      end else if (kind < 84) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          queue_item(CMD_NONZERO, pick_loaded(), random_operand(), i == len - 1);
      end else if (kind < 91) begin
        queue_item(CMD_EMPTY_ROW, $urandom_range(STORE_DEPTH - 1), random_operand(),
                   1'($urandom_range(1)));
      end else if (kind < 97) begin
        // row cut short by an empty row or a restart
        len = $urandom_range(1, 3);
        repeat (len) queue_item(CMD_NONZERO, pick_loaded(), random_operand(), 1'b0);
        queue_item($urandom_range(1) ? CMD_EMPTY_ROW : CMD_RESTART,
                   $urandom_range(STORE_DEPTH - 1), random_operand(),
                   1'($urandom_range(1)));
      end else begin
        queue_item(CMD_RESTART, $urandom_range(STORE_DEPTH - 1), random_operand(),
                   1'($urandom_range(1)));
      end
    end
  endtask

  // every transaction taken and every expected row seen
  task automatic wait_for_drain();
    while (matrix_stream.size() != 0 || in_valid || expected_rows.size() != 0)
      @(negedge clk);
  endtask

  // sequencer
  initial begin
    pace_t schemes[4];
    schemes = '{PACE_FULL, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH};
    row_total   = '0;
    row_number  = '0;
    row_clipped = 1'b0;
    foreach (element_copy[i]) element_copy[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    pace = PACE_BOTH;
    queue_item(CMD_LOAD, 0, 16'h7FFF, 1'b1);           // stray last flag on a load
    queue_item(CMD_LOAD, 1023, 16'h8000, 1'b0);
    queue_item(CMD_LOAD, 'h155, 16'h0100, 1'b0);
    queue_item(CMD_LOAD, 'h2AA, 16'hFFFF, 1'b0);
    queue_item(CMD_NONZERO, 0, 16'h8000, 1'b0);
    queue_item(CMD_NONZERO, 1023, 16'h8000, 1'b1);     // largest positive product
    queue_item(CMD_EMPTY_ROW, 'h2AA, 16'h5555, 1'b1);  // stray last on an empty row
    queue_item(CMD_NONZERO, 'h155, 16'h7FFF, 1'b0);
    queue_item(CMD_EMPTY_ROW, 0, 16'h0000, 1'b0);      // partial sum is dropped
    queue_item(CMD_NONZERO, 'h2AA, 16'h1234, 1'b0);
    queue_item(CMD_RESTART, 'h155, 16'hAAAA, 1'b1);    // restart in mid-row
    queue_item(CMD_NONZERO, 1023, 16'h7FFF, 1'b1);
    queue_item(CMD_LOAD, 0, 16'h0000, 1'b0);
    queue_item(CMD_NONZERO, 0, 16'h7FFF, 1'b1);        // reads the element just loaded
    queue_item(CMD_LOAD, 'h155, 16'h8001, 1'b0);
    queue_item(CMD_NONZERO, 'h155, 16'hFFFF, 1'b1);
    queue_item(CMD_RESTART, 0, 16'h0000, 1'b0);
    wait_for_drain();

    // random part under each pacing scheme, with a pause until drained after each
    foreach (schemes[s]) begin
      pace = schemes[s];
      if (pace == PACE_FULL) hold_requests++;
      stream_random(RANDOM_PER_PACE);
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sparse_matrix_vector_multiply.f -----
hdl/spmv_pkg.sv
hdl/spmv_front.sv
hdl/spmv_queue.sv
hdl/spmv_back.sv
hdl/sparse_matrix_vector_multiply.sv
dv/tb_sparse_matrix_vector_multiply.sv
